// ===== src/afk_pkg.sv =====
// Shared types, constants and CORDIC angle table for the arm forward kinematics unit.
// Used by afk_sincos and arm_forward_kinematics_unit; no dependencies.
package afk_pkg;
	localparam int MAX_STEPS = 24;
	localparam int CW = 34;                 // CORDIC x/y width, Q2.30 with headroom
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam int OUT_W = 19;
	localparam int Q15_W = 16;

	typedef enum logic [1:0] {
		REG_BASE_HEIGHT = 2'd0,
		REG_UPPER_ARM   = 2'd1,
		REG_FOREARM     = 2'd2,
		REG_TOOL_OFFSET = 2'd3
	} reg_idx_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== src/afk_sincos.sv =====
// Pipelined sine/cosine: angle wrap and binary-angle scaling by reciprocal multiplication,
// unrolled CORDIC, Q1.15 rounding. Depends on afk_pkg. Every stage advances on en.
module afk_sincos #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int STEPS = 16,
	parameter int AW = 18
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [AW-1:0]   ang,
	output logic signed [afk_pkg::Q15_W-1:0] sin_q,
	output logic signed [afk_pkg::Q15_W-1:0] cos_q
);
	localparam int CW = afk_pkg::CW;
	localparam longint FULL = longint'(360) << ANGLE_FRAC_BITS;
	localparam int L = $clog2(FULL);
	localparam longint OFS = FULL * (((longint'(1) << (AW - 1)) + FULL - 1) / FULL);
	localparam int NW = $clog2((longint'(1) << (AW - 1)) + OFS);
	localparam int KQ = NW + L;
	localparam int MQW = NW + 2;
	localparam longint MQ = ((longint'(1) << KQ) + FULL - 1) / FULL;
	localparam int QW = NW + MQW - KQ;
	// FULL has odd part 45, so a reciprocal with six guard bits gives an exact floor
	localparam int SB = L + 6;
	localparam longint MB = ((longint'(1) << (32 + SB)) + FULL - 1) / FULL;
	localparam int MBW = $clog2(MB + 1);
	localparam int MLW = MBW / 2;
	localparam int MHW = MBW - MLW;
	localparam int PW = L + MBW;
	localparam int NS = (STEPS < afk_pkg::MAX_STEPS) ? STEPS : afk_pkg::MAX_STEPS;
	localparam logic [NW-1:0] OFS_N = NW'(OFS);
	localparam logic [NW-1:0] FULL_N = NW'(FULL);
	localparam logic [MQW-1:0] MQ_C = MQW'(MQ);
	localparam logic [MLW-1:0] MB_LO = MLW'(MB);
	localparam logic [MHW-1:0] MB_HI = MHW'(MB >> MLW);

	// stage 1: shift angle positive by whole turns, quotient estimate by reciprocal
	logic [NW-1:0] n_w;
	logic [NW-1:0] n_s1;
	logic [NW+MQW-1:0] qp_s1;
	assign n_w = NW'(ang) + OFS_N;
	always_ff @(posedge clk) if (en) begin
		n_s1 <= n_w;
		qp_s1 <= (NW+MQW)'(n_w) * (NW+MQW)'(MQ_C);
	end

	// stage 2: remainder modulo one turn
	logic [QW-1:0] q_w;
	logic [NW-1:0] rem_w;
	logic [L-1:0] r_s2;
	assign q_w = qp_s1[NW+MQW-1:KQ];
	assign rem_w = n_s1 - NW'(q_w) * FULL_N;
	always_ff @(posedge clk) if (en) r_s2 <= rem_w[L-1:0];

	// stage 3: binary angle partial products
	logic [L+MLW-1:0] pl_s3;
	logic [L+MHW-1:0] ph_s3;
	always_ff @(posedge clk) if (en) begin
		pl_s3 <= (L+MLW)'(r_s2) * (L+MLW)'(MB_LO);
		ph_s3 <= (L+MHW)'(r_s2) * (L+MHW)'(MB_HI);
	end
	logic [PW-1:0] bp_w;
	logic [31:0] b_w;
	assign bp_w = (PW'(ph_s3) << MLW) + PW'(pl_s3);
	assign b_w = bp_w[SB+31:SB];

	// stage 4: quadrant fold
	logic [31:0] bq;
	logic flip_w;
	logic [31:0] bsum;
	always_comb begin
		bsum = b_w + 32'h4000_0000;
		flip_w = bsum[31];
		bq = flip_w ? (b_w ^ 32'h8000_0000) : b_w;
	end

	logic signed [CW-1:0] x_p [NS+1];
	logic signed [CW-1:0] y_p [NS+1];
	logic signed [33:0]   z_p [NS+1];
	logic                 f_p [NS+1];
	always_ff @(posedge clk) if (en) begin
		x_p[0] <= afk_pkg::CORDIC_GAIN;
		y_p[0] <= '0;
		z_p[0] <= 34'(signed'(bq));
		f_p[0] <= flip_w;
	end

	for (genvar i = 0; i < NS; i++) begin : g_step
		localparam logic signed [33:0] AT = 34'(afk_pkg::atan_entry(5'(i)));
		always_ff @(posedge clk) if (en) begin
			f_p[i+1] <= f_p[i];
			if (!z_p[i][33]) begin
				x_p[i+1] <= x_p[i] - (y_p[i] >>> i);
				y_p[i+1] <= y_p[i] + (x_p[i] >>> i);
				z_p[i+1] <= z_p[i] - AT;
			end else begin
				x_p[i+1] <= x_p[i] + (y_p[i] >>> i);
				y_p[i+1] <= y_p[i] - (x_p[i] >>> i);
				z_p[i+1] <= z_p[i] + AT;
			end
		end
	end

	function automatic logic signed [afk_pkg::Q15_W-1:0] to_q15(input logic signed [CW-1:0] v);
		logic signed [CW:0] t;
		logic signed [CW-15:0] s;
		t = (CW+1)'(v) + (CW+1)'(1 << 14);
		s = t[CW:15];
		if (s > 32767) return 16'sd32767;
		if (s < -32768) return -16'sd32768;
		return s[15:0];
	endfunction

	always_ff @(posedge clk) if (en) begin
		cos_q <= to_q15(f_p[NS] ? -x_p[NS] : x_p[NS]);
		sin_q <= to_q15(f_p[NS] ? -y_p[NS] : y_p[NS]);
	end
endmodule

// ===== src/arm_forward_kinematics_unit.sv =====
// Arm forward kinematics top level: APB registers, three CORDIC lanes, position math.
// Depends on afk_pkg and afk_sincos.
//  channel | signals                                       | direction
//  in      | in_valid, in_stall, base/shoulder/elbow_angle | request in
//  out     | out_valid, out_stall, pos_x, pos_y, pos_z     | request out
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata  | register access
// One request enters per cycle while in_stall is low.
// The whole pipe advances together; in_stall is raised when the output holds a request
// that is stalled. Reset clears valid bits and restores registers 6, 8, 8, 6.
module arm_forward_kinematics_unit #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int OUT_FRAC_BITS = 8,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [16:0] base_angle,
	input  logic signed [16:0] shoulder_angle,
	input  logic signed [16:0] elbow_angle,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [18:0] pos_x,
	output logic signed [18:0] pos_y,
	output logic signed [18:0] pos_z,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int NS = (CORDIC_STEPS < afk_pkg::MAX_STEPS) ? CORDIC_STEPS : afk_pkg::MAX_STEPS;
	localparam int LAT = NS + 5 + 4;
	localparam int SH_XY = 30 - OUT_FRAC_BITS;
	localparam int SH_Z = 15 - OUT_FRAC_BITS;

	logic [7:0] l1_q, l2_q, l3_q, l4_q;
	afk_pkg::reg_idx_t ridx;
	assign ridx = afk_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 8'd6; l2_q <= 8'd8; l3_q <= 8'd8; l4_q <= 8'd6;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				afk_pkg::REG_BASE_HEIGHT: l1_q <= pwdata[7:0];
				afk_pkg::REG_UPPER_ARM:   l2_q <= pwdata[7:0];
				afk_pkg::REG_FOREARM:     l3_q <= pwdata[7:0];
				afk_pkg::REG_TOOL_OFFSET: l4_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (ridx)
			afk_pkg::REG_BASE_HEIGHT: prdata = {24'd0, l1_q};
			afk_pkg::REG_UPPER_ARM:   prdata = {24'd0, l2_q};
			afk_pkg::REG_FOREARM:     prdata = {24'd0, l3_q};
			afk_pkg::REG_TOOL_OFFSET: prdata = {24'd0, l4_q};
			default: prdata = '0;
		endcase
	end

	logic en;
	logic [LAT-1:0] v_q;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = v_q[LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-2:0], in_valid};
	end

	logic signed [19:0] e2;
	assign e2 = 20'(90 << ANGLE_FRAC_BITS) + 20'(shoulder_angle) + 20'(elbow_angle);

	logic signed [15:0] sb, cb, ss, cs, se, ce;
	afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .AW(18)) u_base (
		.clk(clk), .en(en), .ang(18'(base_angle)), .sin_q(sb), .cos_q(cb));
	afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .AW(18)) u_shld (
		.clk(clk), .en(en), .ang(18'(shoulder_angle)), .sin_q(ss), .cos_q(cs));
	afk_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .AW(20)) u_elb (
		.clk(clk), .en(en), .ang(e2), .sin_q(se), .cos_q(ce));

	// stage A: link products
	logic signed [25:0] p_ss_s1, p_ce_s1, p_cs_s1, p_se_s1;
	logic signed [15:0] sb_s1, cb_s1;
	always_ff @(posedge clk) if (en) begin
		p_ss_s1 <= $signed({1'b0, l2_q}) * ss;
		p_ce_s1 <= $signed({1'b0, l3_q}) * ce;
		p_cs_s1 <= $signed({1'b0, l2_q}) * cs;
		p_se_s1 <= $signed({1'b0, l3_q}) * se;
		sb_s1 <= sb; cb_s1 <= cb;
	end
	// stage B: sums
	logic signed [26:0] d3_s2, z_s2;
	logic signed [15:0] sb_s2, cb_s2;
	always_ff @(posedge clk) if (en) begin
		d3_s2 <= 27'(p_cs_s1) + 27'(p_se_s1) + $signed({4'd0, l4_q, 15'd0});
		z_s2 <= $signed({4'd0, l1_q, 15'd0}) + 27'(p_ss_s1) - 27'(p_ce_s1);
		sb_s2 <= sb_s1; cb_s2 <= cb_s1;
	end
	// stage C: position products
	logic signed [42:0] x_s3, y_s3;
	logic signed [26:0] z_s3;
	always_ff @(posedge clk) if (en) begin
		x_s3 <= d3_s2 * cb_s2;
		y_s3 <= d3_s2 * sb_s2;
		z_s3 <= z_s2;
	end

	function automatic logic signed [18:0] sat19(input logic signed [43:0] v);
		if (v > 44'sd262143) return 19'sd262143;
		if (v < -44'sd262144) return -19'sd262144;
		return v[18:0];
	endfunction
	function automatic logic signed [43:0] rnd(input logic signed [43:0] v, input int sh);
		logic signed [43:0] t;
		t = (sh > 0) ? v + (44'sd1 <<< (sh - 1)) : v;
		return t >>> sh;
	endfunction

	// stage D: round and saturate
	always_ff @(posedge clk) if (en) begin
		pos_x <= sat19(rnd(44'(x_s3), SH_XY));
		pos_y <= sat19(rnd(44'(y_s3), SH_XY));
		pos_z <= sat19(rnd(44'(z_s3), SH_Z));
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_z))
		else $error("stalled request changed");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall)) else $error("stall mismatch");
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall && !in_stall |=> v_q[0] == $past(in_valid)) else $error("valid lost");
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for arm_forward_kinematics_unit: joint-angle requests in, positions out.
// Holds its own CORDIC position predictor and link-length copy; depends on afk_pkg and the RTL.
module tb;
	localparam int ANG_FRAC = 7;
	localparam int POS_FRAC = 8;
	localparam int STEPS = 16;
	localparam longint TURN = longint'(360) << ANG_FRAC;
	localparam longint RIGHT = longint'(90) << ANG_FRAC;
	localparam longint GAIN_Q30 = 652032875;

	typedef struct {
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic signed [18:0] z;
	} position_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [16:0] base_angle;
	logic signed [16:0] shoulder_angle;
	logic signed [16:0] elbow_angle;
	logic out_valid;
	logic out_stall;
	logic signed [18:0] pos_x;
	logic signed [18:0] pos_y;
	logic signed [18:0] pos_z;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	position_t expected_pos[$];
	logic [7:0] link_len[4];
	int mismatches;
	bit steady_send;
	bit steady_recv;
	int hold_cycles;

	arm_forward_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.base_angle(base_angle), .shoulder_angle(shoulder_angle),
		.elbow_angle(elbow_angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint atan_angle(input int i);
		case (i)
			0: return 536870912;
			1: return 316933406;
			2: return 167458907;
			3: return 85004756;
			4: return 42667331;
			5: return 21354465;
			6: return 10679838;
			7: return 5340245;
			8: return 2670163;
			9: return 1335087;
			10: return 667544;
			11: return 333772;
			12: return 166886;
			13: return 83443;
			14: return 41722;
			15: return 20861;
			default: return 0;
		endcase
	endfunction

	function automatic longint round_q15(input longint v);
		longint q;
		q = (v + (longint'(1) << 14)) >>> 15;
		if (q < -32768) q = -32768;
		if (q > 32767) q = 32767;
		return q;
	endfunction

	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint r;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		logic [63:0] wide;
		logic [31:0] b;
		logic [31:0] probe;
		bit flip;
		r = ang % TURN;
		if (r < 0) r += TURN;
		wide = (64'(r) << 32) / 64'(TURN);
		b = wide[31:0];
		probe = b + 32'h4000_0000;
		flip = probe[31];
		if (flip) b = b ^ 32'h8000_0000;
		z = longint'(b);
		if (b[31]) z -= longint'(1) << 32;
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= atan_angle(i);
			end else begin
				x += ys;
				y -= xs;
				z += atan_angle(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = round_q15(x);
		s = round_q15(y);
	endfunction

	function automatic logic signed [18:0] scale_out(input longint v, input int sh);
		longint q;
		q = (v + (longint'(1) << (sh - 1))) >>> sh;
		if (q < -262144) q = -262144;
		if (q > 262143) q = 262143;
		return q[18:0];
	endfunction

	function automatic position_t arm_position(input logic signed [16:0] tb_a,
			input logic signed [16:0] ts_a, input logic signed [16:0] te_a);
		longint sb, cb, ss, cs, se, ce;
		longint l1, l2, l3, l4, d1, d2, d3, zq;
		position_t p;
		l1 = link_len[afk_pkg::REG_BASE_HEIGHT];
		l2 = link_len[afk_pkg::REG_UPPER_ARM];
		l3 = link_len[afk_pkg::REG_FOREARM];
		l4 = link_len[afk_pkg::REG_TOOL_OFFSET];
		sin_cos(longint'(tb_a), sb, cb);
		sin_cos(longint'(ts_a), ss, cs);
		sin_cos(RIGHT + longint'(ts_a) + longint'(te_a), se, ce);
		d1 = l2 * ss;
		d2 = l3 * ce;
		d3 = l2 * cs + l3 * se + (l4 << 15);
		zq = (l1 << 15) + d1 - d2;
		p.x = scale_out(d3 * cb, 30 - POS_FRAC);
		p.y = scale_out(d3 * sb, 30 - POS_FRAC);
		p.z = scale_out(zq, 15 - POS_FRAC);
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic signed [18:0] got,
			input logic signed [18:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk) begin
		position_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pos.size() == 0) begin
				report_mismatch("unexpected position", pos_x, 19'sd0);
			end else begin
				want = expected_pos.pop_front();
				if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
				if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
				if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else if (steady_recv) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 22);
		end
	end

	// call at a falling edge; returns at a falling edge with in_valid still high
	task automatic send_angles(input logic signed [16:0] a_base,
			input logic signed [16:0] a_shoulder, input logic signed [16:0] a_elbow);
		if (!steady_send && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 22);
		end
		in_valid <= 1'b1;
		base_angle <= a_base;
		shoulder_angle <= a_shoulder;
		elbow_angle <= a_elbow;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_pos.push_back(arm_position(a_base, a_shoulder, a_elbow));
		@(negedge clk);
	endtask

	task automatic write_link(input afk_pkg::reg_idx_t idx, input logic [7:0] val);
		in_valid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {$urandom_range(16777215), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		link_len[idx] = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		wait (expected_pos.size() == 0);
		repeat (STEPS + 15) @(negedge clk);
	endtask

	function automatic logic signed [16:0] rand_angle;
		if ($urandom_range(9) == 0) return 17'($urandom);
		return 17'($urandom_range(92160) - 46080);
	endfunction

	task automatic set_links(input logic [7:0] l1, input logic [7:0] l2,
			input logic [7:0] l3, input logic [7:0] l4);
		drain();
		write_link(afk_pkg::REG_BASE_HEIGHT, l1);
		write_link(afk_pkg::REG_UPPER_ARM, l2);
		write_link(afk_pkg::REG_FOREARM, l3);
		write_link(afk_pkg::REG_TOOL_OFFSET, l4);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_angles(rand_angle(), rand_angle(), rand_angle());
	endtask

	task automatic test_directed;
		send_angles(17'sd0, 17'sd0, 17'sd0);
		send_angles(17'sd46080, 17'sd46080, 17'sd46080);
		send_angles(-17'sd46080, -17'sd46080, -17'sd46080);
		send_angles(17'sd11520, 17'sd11520, -17'sd11520);
		send_angles(-17'sd11520, -17'sd11520, 17'sd11520);
		send_angles(17'sd23040, 17'sd23040, 17'sd0);
		send_angles(-17'sd23040, 17'sd0, 17'sd23040);
		send_angles(17'sd34560, -17'sd34560, 17'sd11520);
		send_angles(17'sd65535, -17'sd65536, 17'sd65535);
		send_angles(-17'sd65536, 17'sd65535, -17'sd65536);
		send_angles(17'sd45000, 17'sd46000, 17'sd45000);
		send_angles(17'sd1, -17'sd1, 17'sd5760);
		send_angles(17'sd5760, 17'sd17280, -17'sd28800);
		send_angles(-17'sd1, 17'sd1, -17'sd1);
		send_angles(17'sd11519, 17'sd11521, 17'sd23039);
		send_angles(17'sd43690, -17'sd21845, 17'sd21845);
	endtask

	task automatic test_link_settings;
		set_links(8'd0, 8'd0, 8'd0, 8'd0);
		send_random(60);
		test_directed();
		set_links(8'd255, 8'd255, 8'd255, 8'd255);
		test_directed();
		send_random(60);
		set_links(8'd255, 8'd0, 8'd255, 8'd0);
		send_random(50);
		set_links(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_random(60);
	endtask

	task automatic test_random;
		send_random(150);
		steady_send = 1'b1;
		steady_recv = 1'b1;
		send_random(150);
		steady_send = 1'b0;
		steady_recv = 1'b0;
		send_random(100);
	endtask

	task automatic test_backpressure;
		steady_send = 1'b1;
		hold_cycles = 200;
		send_random(80);
		steady_send = 1'b0;
	endtask

	initial begin
		mismatches = 0;
		steady_send = 1'b0;
		steady_recv = 1'b0;
		hold_cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		base_angle = '0;
		shoulder_angle = '0;
		elbow_angle = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		link_len[afk_pkg::REG_BASE_HEIGHT] = 8'd6;
		link_len[afk_pkg::REG_UPPER_ARM] = 8'd8;
		link_len[afk_pkg::REG_FOREARM] = 8'd8;
		link_len[afk_pkg::REG_TOOL_OFFSET] = 8'd6;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_link_settings();
		test_random();
		test_backpressure();
		drain();
		if (mismatches == 0) begin
			$display("** arm_forward_kinematics_unit: PASSED **");
		end else begin
			$display("** arm_forward_kinematics_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("** arm_forward_kinematics_unit: FAILED **");
		$finish;
	end
endmodule
